FILE: src/btlv_pkg.sv
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and codes for the BER-TLV header parser: parse phases,
// byte kinds and error codes.
// ----------------------------------------------------------------------------
package btlv_pkg;

  typedef enum logic [2:0] {
    PH_TAG1  = 3'd0,
    PH_TAG2  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LENX  = 3'd3,
    PH_VALUE = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERR   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TAG    = 2'd0,
    KIND_LEN    = 2'd1,
    KIND_VALUE  = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_EXT_TAG = 3'd1,
    ERR_MULTI_TAG  = 3'd2,
    ERR_NO_LENGTH  = 3'd3,
    ERR_INDEFINITE = 3'd4,
    ERR_TRUNC_LEN  = 3'd5,
    ERR_OVERFLOW   = 3'd6,
    ERR_VALUE_SHORT = 3'd7
  } err_t;

  localparam logic [7:0] TAG_EXT_MASK = 8'h1f;
  localparam logic [7:0] LEN_LONG_BIT = 8'h80;

endpackage

FILE: src/ber_tlv_header_parser_unit.sv
// ----------------------------------------------------------------------------
// ber_tlv_header_parser_unit
// Parses a single BER-TLV node header from a byte stream, classes every
// byte and reports a node summary on the final byte of each buffer.
// ----------------------------------------------------------------------------
// Output: a result word appears in the cycle after its input word is accepted.
// Throughput: one byte per cycle unless the result side stalls; the parse state updates in the
//   accept cycle, and the single result register drains while the next byte is taken.
// Reset (rst, synchronous): parse state returns to "expect first tag byte",
//   all counters and flags clear, and the result register empties.
module ber_tlv_header_parser_unit
  import btlv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  byte_kind,
  output logic        finished,
  output logic [2:0]  error_code,
  output logic [15:0] tag,
  output logic [1:0]  tag_size,
  output logic        constructed,
  output logic [15:0] value_length,
  output logic [7:0]  length_size,
  output logic        more_follows
);

  // Parse state
  phase_t      phase, phase_next;
  logic [15:0] tag_reg, tag_reg_next;
  logic [1:0]  tag_count, tag_count_next;
  logic        constructed_reg, constructed_reg_next;
  logic [15:0] length_acc, length_acc_next;
  logic [6:0]  length_bytes_left, length_bytes_left_next;
  logic [7:0]  length_field_size, length_field_size_next;
  logic [15:0] value_left, value_left_next;
  logic [2:0]  error_reg, error_reg_next;
  logic        trailing_seen, trailing_seen_next;

  // Result computed from the byte in flight
  kind_t       kind;
  err_t        err;
  logic [6:0]  lbl_dec;
  logic [15:0] vl_dec;

  logic accept;

  // Take a new word whenever the result register is empty or draining.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign lbl_dec = length_bytes_left - 7'd1;
  assign vl_dec  = value_left - 16'd1;

  // Next-state logic: advance the header parse by one byte.
  always_comb begin
    phase_next             = phase;
    tag_reg_next           = tag_reg;
    tag_count_next         = tag_count;
    constructed_reg_next   = constructed_reg;
    length_acc_next        = length_acc;
    length_bytes_left_next = length_bytes_left;
    length_field_size_next = length_field_size;
    value_left_next        = value_left;
    error_reg_next         = error_reg;
    trailing_seen_next     = trailing_seen;
    kind                   = KIND_IGNORE;

    case (phase)
      PH_TAG1: begin
        kind                 = KIND_TAG;
        tag_reg_next         = {8'h00, in_byte};
        tag_count_next       = 2'd1;
        constructed_reg_next = in_byte[5];
        phase_next = ((in_byte & TAG_EXT_MASK) == TAG_EXT_MASK) ? PH_TAG2 : PH_LEN1;
      end
      PH_TAG2: begin
        kind           = KIND_TAG;
        tag_count_next = 2'd2;
        tag_reg_next   = {tag_reg[7:0], in_byte};
        if (in_byte[7]) begin
          error_reg_next = ERR_MULTI_TAG;
          phase_next     = PH_ERR;
        end else begin
          phase_next = PH_LEN1;
        end
      end
      PH_LEN1: begin
        kind                   = KIND_LEN;
        length_field_size_next = 8'd1;
        if ((in_byte & LEN_LONG_BIT) == 8'h00) begin
          // short form: the length is the byte itself
          length_acc_next = {8'h00, in_byte};
          value_left_next = {8'h00, in_byte};
          phase_next      = (in_byte != 8'h00) ? PH_VALUE : PH_DONE;
        end else if (in_byte[6:0] == 7'd0) begin
          error_reg_next = ERR_INDEFINITE;
          phase_next     = PH_ERR;
        end else begin
          length_bytes_left_next = in_byte[6:0];
          length_field_size_next = {1'b0, in_byte[6:0]} + 8'd1;
          length_acc_next        = 16'h0000;
          phase_next             = PH_LENX;
        end
      end
      PH_LENX: begin
        kind = KIND_LEN;
        if (|length_acc[15:8]) begin
          // another byte would push the length past 16 bits
          error_reg_next = ERR_OVERFLOW;
          phase_next     = PH_ERR;
        end else begin
          length_acc_next        = {length_acc[7:0], in_byte};
          length_bytes_left_next = lbl_dec;
          if (lbl_dec == 7'd0) begin
            value_left_next = {length_acc[7:0], in_byte};
            phase_next = ({length_acc[7:0], in_byte} != 16'h0000) ? PH_VALUE : PH_DONE;
          end
        end
      end
      PH_VALUE: begin
        kind            = KIND_VALUE;
        value_left_next = vl_dec;
        if (vl_dec == 16'h0000) begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        kind               = KIND_IGNORE;
        trailing_seen_next = 1'b1;
      end
      default: begin
        kind = KIND_IGNORE;
      end
    endcase
  end

  // Error judged on the final byte, after it has been taken in.
  always_comb begin
    case (phase_next)
      PH_ERR:   err = err_t'(error_reg_next);
      PH_TAG2:  err = ERR_NO_EXT_TAG;
      PH_LEN1:  err = ERR_NO_LENGTH;
      PH_LENX:  err = ERR_TRUNC_LEN;
      PH_VALUE: err = ERR_VALUE_SHORT;
      default:  err = ERR_NONE;
    endcase
  end

  // State registers: restart the parse after the final byte.
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase             <= PH_TAG1;
      tag_reg           <= 16'h0000;
      tag_count         <= 2'd0;
      constructed_reg   <= 1'b0;
      length_acc        <= 16'h0000;
      length_bytes_left <= 7'd0;
      length_field_size <= 8'd0;
      value_left        <= 16'h0000;
      error_reg         <= ERR_NONE;
      trailing_seen     <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      tag_reg           <= tag_reg_next;
      tag_count         <= tag_count_next;
      constructed_reg   <= constructed_reg_next;
      length_acc        <= length_acc_next;
      length_bytes_left <= length_bytes_left_next;
      length_field_size <= length_field_size_next;
      value_left        <= value_left_next;
      error_reg         <= error_reg_next;
      trailing_seen     <= trailing_seen_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: summary fields only on the final byte, length fields
  // only when the node parsed cleanly.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte     <= in_byte;
      byte_kind    <= kind;
      finished     <= last_byte;
      error_code   <= last_byte ? err : ERR_NONE;
      tag          <= last_byte ? tag_reg_next : 16'h0000;
      tag_size     <= last_byte ? tag_count_next : 2'd0;
      constructed  <= last_byte && constructed_reg_next;
      if (last_byte && err == ERR_NONE) begin
        value_length <= length_acc_next;
        length_size  <= length_field_size_next;
        more_follows <= trailing_seen_next;
      end else begin
        value_length <= 16'h0000;
        length_size  <= 8'd0;
        more_follows <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // The parse always restarts after the final byte of a buffer.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> phase == PH_TAG1)
    else $error("parser did not restart after final byte");

  // A stored error state always carries a nonzero code.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERR |-> error_reg != ERR_NONE)
    else $error("error phase without error code");

  // Failed nodes report no length summary.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |->
      value_length == 16'h0000 && length_size == 8'd0 && !more_follows)
    else $error("length summary reported with an error");

  // Non-final words carry no summary.
  a_nonfinal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !finished |->
      error_code == ERR_NONE && tag == 16'h0000 && tag_size == 2'd0)
    else $error("summary fields set on a non-final word");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BER-TLV header parser. Buffers go in one
// byte at a time and a behavioral parser predicts every result word. The
// mix is hand-picked error and corner cases, well-formed nodes with random
// content, damaged and junk buffers, output backpressure and idle gaps.
// ----------------------------------------------------------------------------
module testbench
  import btlv_pkg::*;
;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    logic        fin;
    err_t        err;
    logic [15:0] tag;
    logic [1:0]  tag_size;
    logic        cons;
    logic [15:0] vlen;
    logic [7:0]  lsize;
    logic        more;
  } parsed_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic        finished;
  logic [2:0]  error_code;
  logic [15:0] tag;
  logic [1:0]  tag_size;
  logic        constructed;
  logic [15:0] value_length;
  logic [7:0]  length_size;
  logic        more_follows;

  ber_tlv_header_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_kind    (byte_kind),
    .finished     (finished),
    .error_code   (error_code),
    .tag          (tag),
    .tag_size     (tag_size),
    .constructed  (constructed),
    .value_length (value_length),
    .length_size  (length_size),
    .more_follows (more_follows)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser shadow state.
  phase_t      ph;
  logic [15:0] tag_r;
  logic [1:0]  tag_cnt;
  logic        cons_r;
  logic [15:0] len_acc;
  logic [6:0]  len_left;
  logic [7:0]  len_fsize;
  logic [15:0] val_left;
  err_t        err_r;
  logic        trailing;

  parsed_word_t classified_bytes[$];
  logic [7:0]   node_bytes[$];
  int           parsed_count = 0;
  int           mismatches = 0;
  int           source_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           sink_hold_left = 0;
  int           cycles = 0;

  task automatic clear_parse_state();
    ph        = PH_TAG1;
    tag_r     = '0;
    tag_cnt   = '0;
    cons_r    = 1'b0;
    len_acc   = '0;
    len_left  = '0;
    len_fsize = '0;
    val_left  = '0;
    err_r     = ERR_NONE;
    trailing  = 1'b0;
  endtask

  // Advance the shadow parser by one byte and queue the word it yields.
  task automatic classify_byte(input logic [7:0] b, input logic fin);
    parsed_word_t w;
    err_t         e;
    w = '0;
    w.data = b;
    w.kind = KIND_IGNORE;
    case (ph)
      PH_TAG1: begin
        w.kind  = KIND_TAG;
        tag_r   = {8'h00, b};
        tag_cnt = 2'd1;
        cons_r  = b[5];
        ph = ((b & TAG_EXT_MASK) == TAG_EXT_MASK) ? PH_TAG2 : PH_LEN1;
      end
      PH_TAG2: begin
        w.kind  = KIND_TAG;
        tag_cnt = 2'd2;
        tag_r   = {tag_r[7:0], b};
        if (b[7]) begin
          err_r = ERR_MULTI_TAG;
          ph    = PH_ERR;
        end else begin
          ph = PH_LEN1;
        end
      end
      PH_LEN1: begin
        w.kind    = KIND_LEN;
        len_fsize = 8'd1;
        if ((b & LEN_LONG_BIT) == 8'h00) begin
          len_acc  = {8'h00, b};
          val_left = len_acc;
          ph = (len_acc != 16'd0) ? PH_VALUE : PH_DONE;
        end else if (b[6:0] == 7'd0) begin
          err_r = ERR_INDEFINITE;
          ph    = PH_ERR;
        end else begin
          len_left  = b[6:0];
          len_fsize = {1'b0, b[6:0]} + 8'd1;
          len_acc   = '0;
          ph        = PH_LENX;
        end
      end
      PH_LENX: begin
        w.kind = KIND_LEN;
        if (len_acc > 16'h00ff) begin
          err_r = ERR_OVERFLOW;
          ph    = PH_ERR;
        end else begin
          len_acc  = {len_acc[7:0], b};
          len_left = len_left - 7'd1;
          if (len_left == 7'd0) begin
            val_left = len_acc;
            ph = (len_acc != 16'd0) ? PH_VALUE : PH_DONE;
          end
        end
      end
      PH_VALUE: begin
        w.kind   = KIND_VALUE;
        val_left = val_left - 16'd1;
        if (val_left == 16'd0) ph = PH_DONE;
      end
      PH_DONE: begin
        trailing = 1'b1;
      end
      default: begin
      end
    endcase
    if (w.kind != KIND_IGNORE) parsed_count++;

    if (fin) begin
      // Judge the end by whichever field is still open.
      case (ph)
        PH_ERR:   e = err_r;
        PH_TAG2:  e = ERR_NO_EXT_TAG;
        PH_LEN1:  e = ERR_NO_LENGTH;
        PH_LENX:  e = ERR_TRUNC_LEN;
        PH_VALUE: e = ERR_VALUE_SHORT;
        default:  e = ERR_NONE;
      endcase
      w.fin      = 1'b1;
      w.err      = e;
      w.tag      = tag_r;
      w.tag_size = tag_cnt;
      w.cons     = cons_r;
      if (e == ERR_NONE) begin
        w.vlen  = len_acc;
        w.lsize = len_fsize;
        w.more  = trailing;
      end
      clear_parse_state();
    end
    classified_bytes = {classified_bytes, w};
  endtask

  // Offer one word, hold it until taken, then predict its result.
  task automatic send_word(input logic [7:0] b, input logic fin);
    while (source_idle_pct > 0 && $urandom_range(99) < source_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    classify_byte(b, fin);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < node_bytes.size(); i++)
      send_word(node_bytes[i], i == node_bytes.size() - 1);
  endtask

  // Add one byte at the end of the buffer under construction.
  task automatic append_byte(input logic [7:0] nb);
    node_bytes = {node_bytes, nb};
  endtask

  task automatic push_random_bytes(input int n);
    logic [7:0] rb;
    repeat (n) begin
      rb = 8'($urandom_range(255));
      append_byte(rb);
    end
  endtask

  // Drop valid and hold off until every predicted word has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (classified_bytes.size() != 0);
  endtask

  // Mostly well-formed nodes with random content; the rest are damaged.
  task automatic make_random_buffer();
    int         pick;
    int         vlen;
    int         nlen;
    int         pad;
    int         cut;
    logic [7:0] first;
    logic [7:0] second;
    node_bytes.delete();
    pick  = $urandom_range(99);
    first = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) begin
      first[4:0] = 5'h1f;
      second = 8'($urandom_range(127));
      if (pick < 20) second[7] = 1'b1;
      append_byte(first);
      append_byte(second);
    end else begin
      if (first[4:0] == 5'h1f) first[0] = 1'b0;
      append_byte(first);
    end

    if (pick < 5) begin
      // indefinite length
      append_byte(LEN_LONG_BIT);
      push_random_bytes($urandom_range(3));
    end else if (pick < 10) begin
      // long-form length that runs past 16 bits
      nlen = $urandom_range(3, 8);
      append_byte(LEN_LONG_BIT | nlen[7:0]);
      append_byte(8'($urandom_range(1, 255)));
      push_random_bytes($urandom_range(1, nlen));
    end else if (pick < 15) begin
      node_bytes.delete();
      push_random_bytes($urandom_range(1, 10));
    end else begin
      vlen = ($urandom_range(15) == 0) ? $urandom_range(400) : $urandom_range(24);
      if (vlen < 128 && $urandom_range(1) == 1) begin
        append_byte(vlen[7:0]);
      end else begin
        nlen = (vlen > 255) ? 2 : 1;
        pad  = ($urandom_range(19) == 0) ? $urandom_range(127 - nlen) : $urandom_range(2);
        append_byte(LEN_LONG_BIT | 8'(nlen + pad));
        repeat (pad) append_byte(8'h00);
        if (nlen == 2) append_byte(vlen[15:8]);
        append_byte(vlen[7:0]);
      end
      push_random_bytes(vlen);
      if ($urandom_range(3) == 0) push_random_bytes($urandom_range(1, 4));
      if (pick < 27) begin
        // cut the buffer short somewhere
        cut = $urandom_range(1, node_bytes.size());
        while (node_bytes.size() > cut) void'(node_bytes.pop_back());
      end
    end
  endtask

  task automatic test_directed_cases();
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    node_bytes = '{8'h1f};                                  send_buffer();
    node_bytes = '{8'h00};                                  send_buffer();
    node_bytes = '{8'h5f, 8'h80, 8'h11};                    send_buffer();
    node_bytes = '{8'h30, 8'h00, 8'haa};                    send_buffer();
    node_bytes = '{8'h04, 8'h80, 8'h55};                    send_buffer();
    node_bytes = '{8'h04, 8'h82, 8'h01};                    send_buffer();
    node_bytes = '{8'h04, 8'h83, 8'h01, 8'h00, 8'h00};      send_buffer();
    node_bytes = '{8'h04, 8'h02, 8'hff};                    send_buffer();
    node_bytes = '{8'hff, 8'h7f, 8'h81, 8'h01, 8'hee};      send_buffer();
  endtask

  task automatic test_random_buffers(input int src_pct, input int snk_pct, input int count);
    int start;
    source_idle_pct = src_pct;
    sink_idle_pct   = snk_pct;
    start = parsed_count;
    while (parsed_count - start < count) begin
      make_random_buffer();
      send_buffer();
    end
  endtask

  // Hold the result side off for a long stretch while words keep coming,
  // so the block fills and backs up its input.
  task automatic test_output_stall();
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    sink_hold_left  = 250;
    while (sink_hold_left > 0) begin
      make_random_buffer();
      send_buffer();
    end
  endtask

  always @(posedge clk) begin
    if (sink_hold_left > 0) begin
      out_ready <= 1'b0;
      sink_hold_left = sink_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic string describe_word(input parsed_word_t w);
    return $sformatf({"byte=%02h kind=%0d fin=%0d err=%0d tag=%04h tsz=%0d ",
                      "cons=%0d vlen=%0d lsz=%0d more=%0d"},
                     w.data, w.kind, w.fin, w.err, w.tag, w.tag_size, w.cons,
                     w.vlen, w.lsize, w.more);
  endfunction

  always @(posedge clk) begin : check_words
    parsed_word_t got;
    parsed_word_t want;
    if (!rst && out_valid && out_ready) begin
      got.data     = out_byte;
      got.kind     = kind_t'(byte_kind);
      got.fin      = finished;
      got.err      = err_t'(error_code);
      got.tag      = tag;
      got.tag_size = tag_size;
      got.cons     = constructed;
      got.vlen     = value_length;
      got.lsize    = length_size;
      got.more     = more_follows;
      if (classified_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected word: %s", describe_word(got));
      end else begin
        want = classified_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("mismatch\n  expected %s\n  actual   %s",
                     describe_word(want), describe_word(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clear_parse_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    wait_for_drain();
    test_output_stall();
    wait_for_drain();
    test_random_buffers(17, 45, 400);
    wait_for_drain();
    test_random_buffers(45, 17, 400);
    wait_for_drain();
    test_random_buffers(0, 0, 350);
    wait_for_drain();
    repeat (4) @(posedge clk);
    mismatches += classified_bytes.size();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
